// File: design/bit_unpack_match_counter_macros.svh
// Assertion macros used by bumc_dp.sv.
`ifndef BIT_UNPACK_MATCH_COUNTER_MACROS_SVH
`define BIT_UNPACK_MATCH_COUNTER_MACROS_SVH

`ifndef SYNTHESIS

`define BUMC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define BUMC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BUMC_ASSERT_IMPLY(lbl, ante, cons)

`define BUMC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: design/bumc_pkg.sv
package bumc_pkg;

    localparam int unsigned WORD_W       = 32;
    localparam int unsigned WIDTH_W      = 6;
    localparam int unsigned BITS_W       = 7;
    localparam int unsigned TAKEN_W      = 6;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH    = 6'd32;
    localparam logic [TAKEN_W-1:0] MAX_PER_WORD = 6'd32;

    localparam logic [1:0] REG_VALUE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_VALUE_COUNT  = 2'd1;
    localparam logic [1:0] REG_TARGET_VALUE = 2'd2;
    localparam logic [1:0] REG_EMIT_VALUES  = 2'd3;

    localparam logic [WIDTH_W-1:0] RST_VALUE_WIDTH  = 6'd8;
    localparam logic [WORD_W-1:0]  RST_VALUE_COUNT  = 32'd0;
    localparam logic [WORD_W-1:0]  RST_TARGET_VALUE = 32'd0;
    localparam logic               RST_EMIT_VALUES  = 1'b1;

    localparam logic KIND_VALUE = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    typedef struct packed {
        logic [WIDTH_W-1:0] value_width;
        logic [WORD_W-1:0]  value_count;
        logic [WORD_W-1:0]  target_value;
        logic               emit_values;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXTRACT,
        ST_COUNT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic send_count;
    } ctrl_cmd_t;

    typedef struct packed {
        logic w_zero;
        logic more_values;
        logic step_pending;
        logic step_ready;
        logic in_last;
        logic last_word;
        logic out_free;
    } ctrl_sts_t;

endpackage

// File: design/bit_unpack_match_counter.sv
// Unpacks values of value_width bits, packed LSB first across 32-bit words, compares each
// with target_value and counts the matches. With emit_values set every decoded value is
// sent as a word with tuser 0; the word flagged tlast on input produces a final count word
// with tuser 1 and tlast set, after which the stream state is cleared. A single extraction
// unit removes one value per cycle while emit_values is clear or the output is free. An
// input word is accepted, up to 32 values are taken from it and a closing step follows
// (when values are wanted); a count word follows the last input word. Output back-pressure
// stalls only while a decoded or count word waits for the output register. The user must
// write configuration through the APB port only while no stream is in flight (unenforced).
module bit_unpack_match_counter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // packed_word
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // decoded_value [31:0], match_total [63:32]
    output logic        m_tuser,   // kind
    output logic        m_tlast
);
    import bumc_pkg::*;

    cfg_t      cfg;
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    bumc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bumc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bumc_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: design/bumc_regs.sv
module bumc_regs
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output bumc_pkg::cfg_t   cfg
);
    import bumc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_VALUE_WIDTH:  cfg_next.value_width  = pwdata[WIDTH_W-1:0];
                REG_VALUE_COUNT:  cfg_next.value_count  = pwdata;
                REG_TARGET_VALUE: cfg_next.target_value = pwdata;
                REG_EMIT_VALUES:  cfg_next.emit_values  = pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_VALUE_WIDTH:  prdata = {26'd0, cfg_reg.value_width};
            REG_VALUE_COUNT:  prdata = cfg_reg.value_count;
            REG_TARGET_VALUE: prdata = cfg_reg.target_value;
            REG_EMIT_VALUES:  prdata = {31'd0, cfg_reg.emit_values};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.value_width  <= RST_VALUE_WIDTH;
            cfg_reg.value_count  <= RST_VALUE_COUNT;
            cfg_reg.target_value <= RST_TARGET_VALUE;
            cfg_reg.emit_values  <= RST_EMIT_VALUES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: design/bumc_ctrl.sv
module bumc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  bumc_pkg::ctrl_sts_t   sts,
    output bumc_pkg::ctrl_cmd_t   cmd
);
    import bumc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (!sts.w_zero && sts.more_values)
                    begin
                        state_next = ST_EXTRACT;
                    end
                    else if (sts.in_last)
                    begin
                        state_next = ST_COUNT;
                    end
                end
            end
            ST_EXTRACT:
            begin
                if (sts.step_pending)
                begin
                    cmd.step = sts.step_ready;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = sts.last_word ? ST_COUNT : ST_IDLE;
                end
            end
            ST_COUNT:
            begin
                if (sts.out_free)
                begin
                    cmd.send_count = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/bumc_dp.sv
`include "bit_unpack_match_counter_macros.svh"

module bumc_dp
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bumc_pkg::cfg_t        cfg,
    input  bumc_pkg::ctrl_cmd_t   cmd,
    output bumc_pkg::ctrl_sts_t   sts,
    input  logic [31:0]           s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);
    import bumc_pkg::*;

    logic [63:0]         buf_reg,   buf_next;
    logic [BITS_W-1:0]   bb_reg,    bb_next;
    logic [WORD_W-1:0]   done_reg,  done_next;
    logic [WORD_W-1:0]   match_reg, match_next;
    logic [TAKEN_W-1:0]  taken_reg, taken_next;
    logic                last_reg,  last_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [63:0]         m_tdata_reg,  m_tdata_next;
    logic                m_tuser_reg,  m_tuser_next;
    logic                m_tlast_reg,  m_tlast_next;

    logic [WIDTH_W-1:0]  w;
    logic [WORD_W-1:0]   mask;
    logic [WORD_W-1:0]   value;
    logic [WORD_W-1:0]   count_value;
    logic                more;
    logic                cond;
    logic                out_free;

    assign w        = (cfg.value_width > MAX_WIDTH) ? MAX_WIDTH : cfg.value_width;
    assign mask     = WORD_W'(~(64'hFFFF_FFFF_FFFF_FFFF << w));
    assign value    = buf_reg[WORD_W-1:0] & mask;
    assign more     = done_reg < cfg.value_count;
    assign cond     = (bb_reg >= {1'b0, w}) && more && (taken_reg < MAX_PER_WORD);
    assign out_free = !m_tvalid_reg || m_tready;

    assign count_value = (w == '0)
                         ? ((cfg.target_value == '0) ? cfg.value_count : '0)
                         : match_reg;

    assign sts.w_zero       = (w == '0);
    assign sts.more_values  = more;
    assign sts.step_pending = cond;
    assign sts.step_ready   = cond && (!cfg.emit_values || out_free);
    assign sts.in_last      = s_tlast;
    assign sts.last_word    = last_reg;
    assign sts.out_free     = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb
    begin
        buf_next      = buf_reg;
        bb_next       = bb_reg;
        done_next     = done_reg;
        match_next    = match_reg;
        taken_next    = taken_reg;
        last_next     = last_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;

        if (cmd.load)
        begin
            last_next = s_tlast;
            if ((w != '0) && more)
            begin
                buf_next   = buf_reg | ({32'd0, s_tdata} << bb_reg);
                bb_next    = bb_reg + 7'd32;
                taken_next = '0;
            end
        end

        if (cmd.step)
        begin
            buf_next   = buf_reg >> w;
            bb_next    = bb_reg - {1'b0, w};
            done_next  = done_reg + 32'd1;
            taken_next = taken_reg + 6'd1;
            if (value == cfg.target_value)
            begin
                match_next = match_reg + 32'd1;
            end
            if (cfg.emit_values)
            begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = {32'd0, value};
                m_tuser_next  = KIND_VALUE;
                m_tlast_next  = 1'b0;
            end
        end

        if (cmd.finish)
        begin
            if (!more)
            begin
                buf_next = '0;
                bb_next  = '0;
            end
            else if (bb_reg > 7'd32)
            begin
                buf_next = {32'd0, buf_reg[31:0]};
                bb_next  = 7'd32;
            end
        end

        if (cmd.send_count)
        begin
            buf_next      = '0;
            bb_next       = '0;
            done_next     = '0;
            match_next    = '0;
            m_tvalid_next = 1'b1;
            m_tdata_next  = {count_value, 32'd0};
            m_tuser_next  = KIND_COUNT;
            m_tlast_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg      <= '0;
            bb_reg       <= '0;
            done_reg     <= '0;
            match_reg    <= '0;
            taken_reg    <= '0;
            last_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            buf_reg      <= buf_next;
            bb_reg       <= bb_next;
            done_reg     <= done_next;
            match_reg    <= match_next;
            taken_reg    <= taken_next;
            last_reg     <= last_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    `BUMC_ASSERT_IMPLY(a_step_has_room, cmd.step && cfg.emit_values, out_free)
    `BUMC_ASSERT_NEXT(a_step_counts, cmd.step, done_reg == $past(done_reg) + 32'd1)
    `BUMC_ASSERT_NEXT(a_count_marked, cmd.send_count,
        m_tvalid && (m_tuser == KIND_COUNT) && m_tlast && (done_reg == '0))
    `BUMC_ASSERT_IMPLY(a_buffer_bound, 1'b1, bb_reg <= 7'd64)

endmodule

// File: bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bumc_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic [31:0] total;
        logic        eor;
    } decode_result_t;

    typedef struct packed {
        logic [31:0] data;
        logic        is_last;
    } stream_word_t;

    localparam int unsigned RANDOM_WORDS = 300;
    localparam int unsigned QUIET_WORDS  = 40;
    localparam int unsigned SETTLE_CYCLES = 50;

    logic        clk;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // packed_word
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // decoded_value [31:0], match_total [63:32]
    logic        m_tuser;         // kind
    logic        m_tlast;

    // Mirror of the configuration registers.
    logic [5:0]  cfg_width  = RST_VALUE_WIDTH;
    logic [31:0] cfg_count  = RST_VALUE_COUNT;
    logic [31:0] cfg_target = RST_TARGET_VALUE;
    logic        cfg_emit   = RST_EMIT_VALUES;

    // Predicted stream state.
    logic [63:0] pend_bits    = '0;
    int unsigned pend_count   = 0;
    logic [31:0] values_seen  = '0;
    logic [31:0] match_count  = '0;

    decode_result_t expected_results[$];
    stream_word_t   pending_words[$];

    int unsigned words_queued = 0;
    int unsigned words_taken  = 0;
    int          error_count  = 0;
    bit          word_taken   = 1'b0;
    bit          idle_on      = 1'b1;
    int unsigned send_gap     = 0;
    int unsigned hold_gap     = 0;

    bit_unpack_match_counter u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void post_result(input logic kind, input logic [31:0] value,
                                        input logic [31:0] total, input logic eor);
        decode_result_t r;
        r.kind  = kind;
        r.value = value;
        r.total = total;
        r.eor   = eor;
        expected_results.push_back(r);
    endfunction

    function automatic void unpack_word(input logic [31:0] word, input logic is_last);
        int unsigned w;
        int unsigned taken;
        logic [31:0] mask;
        logic [31:0] v;
        w = (cfg_width > 6'd32) ? 32 : cfg_width;
        if (w == 0)
        begin
            if (is_last)
                match_count = (cfg_target == '0) ? cfg_count : '0;
        end
        else
        begin
            mask = (w < 32) ? ((32'd1 << w) - 32'd1) : 32'hFFFF_FFFF;
            if (values_seen < cfg_count)
            begin
                taken = 0;
                if (pend_count > 32)
                    pend_count = 32;
                pend_bits |= {32'd0, word} << pend_count;
                pend_count += 32;
                while (pend_count >= w && values_seen < cfg_count && taken < 32)
                begin
                    v = pend_bits[31:0] & mask;
                    pend_bits = pend_bits >> w;
                    pend_count -= w;
                    values_seen++;
                    taken++;
                    if (v == cfg_target)
                        match_count++;
                    if (cfg_emit)
                        post_result(KIND_VALUE, v, '0, 1'b0);
                end
                if (values_seen >= cfg_count)
                begin
                    pend_bits  = '0;
                    pend_count = 0;
                end
                else if (pend_count > 32)
                begin
                    pend_bits  = pend_bits & 64'hFFFF_FFFF;
                    pend_count = 32;
                end
            end
        end
        if (is_last)
        begin
            post_result(KIND_COUNT, '0, match_count, 1'b1);
            pend_bits   = '0;
            pend_count  = 0;
            values_seen = '0;
            match_count = '0;
        end
    endfunction

    // Input side: hold each word until taken, with random gaps between words.
    always @(negedge clk)
    begin
        stream_word_t item;
        if (rst_n && (!s_tvalid || word_taken))
        begin
            word_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                item = pending_words.pop_front();
                s_tdata  <= item.data;
                s_tlast  <= item.is_last;
                s_tvalid <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 10);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Output side: random stall bursts.
    always @(negedge clk)
    begin
        if (hold_gap > 0)
        begin
            hold_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0)
                hold_gap = $urandom_range(1, 10);
        end
    end

    always @(posedge clk)
    begin
        decode_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                unpack_word(s_tdata, s_tlast);
                words_taken++;
                word_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected word: kind %0d, value %h, total %0d, last %0d",
                           m_tuser, m_tdata[31:0], m_tdata[63:32], m_tlast);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                        error_count++;
                    end
                    if (m_tdata[31:0] !== want.value)
                    begin
                        $error("decoded_value: expected %h, got %h", want.value, m_tdata[31:0]);
                        error_count++;
                    end
                    if (m_tdata[63:32] !== want.total)
                    begin
                        $error("match_total: expected %0d, got %0d", want.total, m_tdata[63:32]);
                        error_count++;
                    end
                    if (m_tlast !== want.eor)
                    begin
                        $error("end_of_run: expected %0d, got %0d", want.eor, m_tlast);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic drain();
        while (words_taken != words_queued || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_VALUE_WIDTH:  cfg_width  = data[5:0];
            REG_VALUE_COUNT:  cfg_count  = data;
            REG_TARGET_VALUE: cfg_target = data;
            REG_EMIT_VALUES:  cfg_emit   = data[0];
            default: ;
        endcase
    endtask

    task automatic configure(input int unsigned width, input logic [31:0] count,
                             input logic [31:0] target, input logic emit);
        drain();
        write_reg(REG_VALUE_WIDTH, width);
        write_reg(REG_VALUE_COUNT, count);
        write_reg(REG_TARGET_VALUE, target);
        write_reg(REG_EMIT_VALUES, {31'd0, emit});
    endtask

    task automatic queue_word(input logic [31:0] data, input logic is_last);
        stream_word_t item;
        item.data    = data;
        item.is_last = is_last;
        pending_words.push_back(item);
        words_queued++;
    endtask

    // Mostly well-formed streams; some run short, some carry surplus bits.
    task automatic random_stream();
        int unsigned n_words;
        int unsigned w;
        int unsigned eff;
        int unsigned cnt;
        logic [31:0] mask;
        logic [31:0] tgt;
        logic [31:0] data;
        int unsigned k;
        n_words = $urandom_range(1, 6);
        case ($urandom_range(0, 9))
            0: w = 0;
            1: w = $urandom_range(33, 63);
            2: w = 1;
            3: w = 32;
            default: w = $urandom_range(1, 32);
        endcase
        eff  = (w > 32) ? 32 : w;
        mask = (eff == 0) ? 32'd0 : ((eff == 32) ? 32'hFFFF_FFFF : ((32'd1 << eff) - 32'd1));
        if (eff == 0)
            cnt = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 100);
        else
        begin
            cnt = n_words * 32 / eff;
            case ($urandom_range(0, 7))
                0: cnt = cnt - $urandom_range(0, cnt);
                1: cnt = cnt + $urandom_range(1, 40);
                2: cnt = 32'hFFFF_FFFF;
                3: cnt = 0;
                default: ;
            endcase
        end
        case ($urandom_range(0, 9))
            0, 1, 2: tgt = '0;
            3:       tgt = mask;
            4:       tgt = $urandom;
            default: tgt = $urandom & mask;
        endcase
        configure(w, cnt, tgt, $urandom_range(0, 3) != 0);
        for (k = 0; k < n_words; k++)
        begin
            case ($urandom_range(0, 7))
                0:       data = '0;
                1:       data = 32'hFFFF_FFFF;
                default: data = $urandom;
            endcase
            if (n_words > 1 && k == n_words / 2 && $urandom_range(0, 9) == 0)
            begin
                drain();
                write_reg(REG_VALUE_WIDTH, $urandom_range(1, 32));
            end
            queue_word(data, k == n_words - 1);
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Settings after reset: no values wanted, count only.
        queue_word(32'h0000_0000, 1'b1);

        // Full width with all-ones target, then a surplus word.
        configure(32, 2, 32'hFFFF_FFFF, 1'b1);
        queue_word(32'hFFFF_FFFF, 1'b0);
        queue_word(32'h0000_0000, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b1);

        // One-bit values; the second word is only partly used.
        configure(1, 40, 1, 1'b1);
        queue_word(32'hAAAA_AAAA, 1'b0);
        queue_word(32'h5555_5555, 1'b1);

        // Zero width: ordinary words are ignored, only the count comes out.
        configure(0, 5, 0, 1'b1);
        queue_word(32'h1234_5678, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b1);
        drain();
        write_reg(REG_TARGET_VALUE, 32'd3);
        queue_word(32'h0000_0000, 1'b1);

        // Width beyond 32 acts as 32.
        configure(63, 1, 32'h8000_0001, 1'b1);
        queue_word(32'h8000_0001, 1'b1);

        // Target wider than the value, values not sent.
        configure(4, 8, 32'h10, 1'b0);
        queue_word(32'h0000_0000, 1'b1);

        // Stream ends before all values are complete.
        configure(12, 10, 32'h211, 1'b1);
        queue_word(32'h1111_1111, 1'b0);
        queue_word(32'h2222_2222, 1'b1);

        // Width changes while bits are still buffered.
        configure(20, 32'hFFFF_FFFF, 0, 1'b1);
        queue_word(32'hDEAD_BEEF, 1'b0);
        drain();
        write_reg(REG_VALUE_WIDTH, 5);
        queue_word(32'h0000_0000, 1'b0);
        drain();
        write_reg(REG_VALUE_WIDTH, 1);
        queue_word(32'hFFFF_0000, 1'b0);
        queue_word(32'h1234_5678, 1'b1);

        while (words_queued < 17 + RANDOM_WORDS)
        begin
            if (words_queued + QUIET_WORDS >= 17 + RANDOM_WORDS)
                idle_on = 1'b0;
            random_stream();
        end

        drain();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/bumc_pkg.sv
design/bumc_regs.sv
design/bumc_ctrl.sv
design/bumc_dp.sv
design/bit_unpack_match_counter.sv
bench/testbench.sv
